// ----- rtl/bpa_pkg.sv -----
// bpa_pkg: constants, codes, command and status structs of the buddy page allocator
// used by bpa_ctrl, bpa_datapath, buddy_page_allocator_unit and bpa_checker
// no dependencies
package bpa_pkg;

	localparam int MAX_PAGES   = 4096;
	localparam int ORDER_COUNT = 11;
	localparam int PAGE_SHIFT  = 12;

	localparam int PG_W   = $clog2(MAX_PAGES);
	localparam int LINK_W = PG_W + 1;
	localparam int ORD_W  = 4;
	localparam int CNT_W  = PG_W + 1;

	localparam logic [LINK_W-1:0] NIL_LINK  = LINK_W'(MAX_PAGES);
	localparam logic [ORD_W-1:0]  FREE_MARK = '1;
	localparam logic [ORD_W-1:0]  TOP_ORD   = ORD_W'(ORDER_COUNT - 1);

	// operation codes of an input word
	localparam logic [1:0] FN_INIT  = 2'd0;
	localparam logic [1:0] FN_ALLOC = 2'd1;
	localparam logic [1:0] FN_FREE  = 2'd2;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_NOINIT  = 3'd1,
		ST_BADSIZE = 3'd2,
		ST_OOM     = 3'd3,
		ST_IGNORED = 3'd4
	} st_code_t;

	// datapath commands
	typedef enum logic [4:0] {
		OP_NONE, OP_CLR_STEP, OP_LOAD, OP_INIT_SETUP, OP_INIT_PICK, OP_INIT_ADV,
		OP_TOG_RD, OP_TOG_WR, OP_PUSH_A_PG, OP_PUSH_A_SPLIT, OP_PUSH_B,
		OP_UL_RD_PG, OP_UL_RD_BUDDY, OP_UL_WR, OP_ALLOC_FIND, OP_DEC_ORD,
		OP_ALLOC_DONE, OP_ORD_RD, OP_FREE_TAKE, OP_MERGE, OP_RESULT
	} op_t;

	typedef struct packed {
		op_t      op;
		st_code_t code;
		logic     grant;
	} cmd_t;

	typedef struct packed {
		logic [1:0] func;
		logic       ready;
		logic       cfg_zero;
		logic       size_bad;
		logic       found;
		logic       pg_ok;
		logic       ord_bad;
		logic       ord_lt_max;
		logic       ord_gt_want;
		logic       tog_new;
		logic       rem_zero;
		logic       clr_done;
	} sts_t;

	// request size to order: {bad, order}
	function automatic logic [ORD_W:0] want_of(input logic [31:0] bytes);
		logic [31:0] q;
		logic [ORD_W-1:0] w;
		logic bad;
		q = (bytes - 32'd1) >> PAGE_SHIFT;
		w = '0;
		bad = (bytes == 32'd0) || ((q >> (ORDER_COUNT - 1)) != 32'd0);
		for (int i = 0; i < ORDER_COUNT - 1; i++) begin
			if (q[i])
				w = ORD_W'(i + 1);
		end
		return {bad, w};
	endfunction

	// flat address of the toggle bit of a buddy pair
	function automatic logic [PG_W-1:0] pair_addr(input logic [ORD_W-1:0] ord,
			input logic [PG_W-1:0] pg);
		logic [CNT_W-1:0] base;
		logic [CNT_W-1:0] idx;
		base = CNT_W'(MAX_PAGES) - (CNT_W'(MAX_PAGES) >> ord);
		idx = {1'b0, pg} >> (ord + ORD_W'(1));
		return PG_W'(base + idx);
	endfunction

	// largest aligned block that fits the remaining page count
	function automatic logic [ORD_W-1:0] init_pick(input logic [CNT_W-1:0] off,
			input logic [CNT_W-1:0] rem);
		logic [ORD_W-1:0] o;
		logic [CNT_W-1:0] sz;
		o = '0;
		for (int k = 0; k < ORDER_COUNT; k++) begin
			sz = CNT_W'(1) << k;
			if (sz <= rem && (off & (sz - CNT_W'(1))) == '0)
				o = ORD_W'(k);
		end
		return o;
	endfunction

endpackage

// ----- rtl/bpa_ctrl.sv -----
// bpa_ctrl: sequencer of the buddy page allocator
// issues one datapath command per cycle from the datapath status; uses bpa_pkg
module bpa_ctrl import bpa_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  sts_t sts,
	output cmd_t cmd,
	output logic busy
);

	typedef enum logic [26:0] {
		S_RCLR  = 27'd1 << 0,
		S_IDLE  = 27'd1 << 1,
		S_DISP  = 27'd1 << 2,
		S_ICLR  = 27'd1 << 3,
		S_IPICK = 27'd1 << 4,
		S_IT1   = 27'd1 << 5,
		S_IT2   = 27'd1 << 6,
		S_IPA   = 27'd1 << 7,
		S_IPB   = 27'd1 << 8,
		S_IADV  = 27'd1 << 9,
		S_AUL1  = 27'd1 << 10,
		S_AUL2  = 27'd1 << 11,
		S_AT1   = 27'd1 << 12,
		S_AT2   = 27'd1 << 13,
		S_ASPL  = 27'd1 << 14,
		S_APA   = 27'd1 << 15,
		S_APB   = 27'd1 << 16,
		S_AFIN  = 27'd1 << 17,
		S_FORD  = 27'd1 << 18,
		S_FLOOP = 27'd1 << 19,
		S_FT2   = 27'd1 << 20,
		S_FPA   = 27'd1 << 21,
		S_FPB   = 27'd1 << 22,
		S_FFIN  = 27'd1 << 23,
		S_FUL1  = 27'd1 << 24,
		S_FUL2  = 27'd1 << 25,
		S_FMRG  = 27'd1 << 26
	} state_t;

	state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_RCLR;
		else
			state_q <= state_d;
	end

	assign busy = (state_q != S_IDLE);

	// next state and command
	always_comb begin
		state_d = state_q;
		cmd = '{op: OP_NONE, code: ST_OK, grant: 1'b0};
		case (state_q)
			S_RCLR: begin
				cmd.op = OP_CLR_STEP;
				if (sts.clr_done)
					state_d = S_IDLE;
			end
			S_IDLE: begin
				if (start) begin
					cmd.op = OP_LOAD;
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				state_d = S_IDLE;
				case (sts.func)
					FN_INIT: begin
						if (sts.cfg_zero) begin
							cmd.op = OP_RESULT;
							cmd.code = ST_BADSIZE;
						end else begin
							cmd.op = OP_INIT_SETUP;
							state_d = S_ICLR;
						end
					end
					FN_ALLOC: begin
						cmd.op = OP_RESULT;
						if (!sts.ready)
							cmd.code = ST_NOINIT;
						else if (sts.size_bad)
							cmd.code = ST_BADSIZE;
						else if (!sts.found)
							cmd.code = ST_OOM;
						else begin
							cmd.op = OP_ALLOC_FIND;
							state_d = S_AUL1;
						end
					end
					FN_FREE: begin
						cmd.op = OP_RESULT;
						if (!sts.ready)
							cmd.code = ST_NOINIT;
						else if (!sts.pg_ok)
							cmd.code = ST_IGNORED;
						else begin
							cmd.op = OP_ORD_RD;
							state_d = S_FORD;
						end
					end
					default: begin
						cmd.op = OP_RESULT;
						cmd.code = ST_IGNORED;
					end
				endcase
			end
			// init: sweep, then carve blocks
			S_ICLR: begin
				cmd.op = OP_CLR_STEP;
				if (sts.clr_done)
					state_d = S_IPICK;
			end
			S_IPICK: begin
				if (sts.rem_zero) begin
					cmd.op = OP_RESULT;
					state_d = S_IDLE;
				end else begin
					cmd.op = OP_INIT_PICK;
					state_d = S_IT1;
				end
			end
			S_IT1: begin
				cmd.op = OP_TOG_RD;
				state_d = S_IT2;
			end
			S_IT2: begin
				cmd.op = OP_TOG_WR;
				state_d = S_IPA;
			end
			S_IPA: begin
				cmd.op = OP_PUSH_A_PG;
				state_d = S_IPB;
			end
			S_IPB: begin
				cmd.op = OP_PUSH_B;
				state_d = S_IADV;
			end
			S_IADV: begin
				cmd.op = OP_INIT_ADV;
				state_d = S_IPICK;
			end
			// allocate: unlink head, toggle, split down
			S_AUL1: begin
				cmd.op = OP_UL_RD_PG;
				state_d = S_AUL2;
			end
			S_AUL2: begin
				cmd.op = OP_UL_WR;
				state_d = S_AT1;
			end
			S_AT1: begin
				cmd.op = OP_TOG_RD;
				state_d = S_AT2;
			end
			S_AT2: begin
				cmd.op = OP_TOG_WR;
				state_d = S_ASPL;
			end
			S_ASPL: begin
				if (sts.ord_gt_want) begin
					cmd.op = OP_DEC_ORD;
					state_d = S_APA;
				end else begin
					cmd.op = OP_ALLOC_DONE;
					state_d = S_AFIN;
				end
			end
			S_APA: begin
				cmd.op = OP_PUSH_A_SPLIT;
				state_d = S_APB;
			end
			S_APB: begin
				cmd.op = OP_PUSH_B;
				state_d = S_AT1;
			end
			S_AFIN: begin
				cmd.op = OP_RESULT;
				cmd.grant = 1'b1;
				state_d = S_IDLE;
			end
			// free: check stored order, merge up
			S_FORD: begin
				if (sts.ord_bad) begin
					cmd.op = OP_RESULT;
					cmd.code = ST_IGNORED;
					state_d = S_IDLE;
				end else begin
					cmd.op = OP_FREE_TAKE;
					state_d = S_FLOOP;
				end
			end
			S_FLOOP: begin
				if (sts.ord_lt_max) begin
					cmd.op = OP_TOG_RD;
					state_d = S_FT2;
				end else begin
					cmd.op = OP_PUSH_A_PG;
					state_d = S_FPB;
				end
			end
			S_FT2: begin
				cmd.op = OP_TOG_WR;
				state_d = sts.tog_new ? S_FPA : S_FUL1;
			end
			S_FPA: begin
				cmd.op = OP_PUSH_A_PG;
				state_d = S_FPB;
			end
			S_FPB: begin
				cmd.op = OP_PUSH_B;
				state_d = S_FFIN;
			end
			S_FFIN: begin
				cmd.op = OP_RESULT;
				state_d = S_IDLE;
			end
			S_FUL1: begin
				cmd.op = OP_UL_RD_BUDDY;
				state_d = S_FUL2;
			end
			S_FUL2: begin
				cmd.op = OP_UL_WR;
				state_d = S_FMRG;
			end
			S_FMRG: begin
				cmd.op = OP_MERGE;
				state_d = S_FLOOP;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// ----- rtl/bpa_datapath.sv -----
// bpa_datapath: list heads, link, order and pair-bit memories, counters and result word
// executes one bpa_ctrl command per cycle; uses bpa_pkg
module bpa_datapath import bpa_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  cmd_t                cmd,
	output sts_t                sts,
	input  logic [1:0]          func,
	input  logic [31:0]         request_bytes,
	input  logic [PG_W-1:0]     page,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [CNT_W-1:0]    cfg_data,
	output logic                done,
	output logic [2:0]          status,
	output logic [PG_W-1:0]     granted_page,
	output logic [CNT_W-1:0]    used_pages,
	output logic [CNT_W-1:0]    total_pages
);

	logic [LINK_W-1:0] next_mem [MAX_PAGES];
	logic [LINK_W-1:0] prev_mem [MAX_PAGES];
	logic [ORD_W-1:0]  order_mem [MAX_PAGES];
	logic              pair_mem [MAX_PAGES];

	logic [LINK_W-1:0] head_q [ORDER_COUNT];
	logic [LINK_W-1:0] next_rd_q, prev_rd_q;
	logic [ORD_W-1:0]  order_rd_q;
	logic              pair_rd_q;

	logic [1:0]        func_q;
	logic [ORD_W-1:0]  want_q, ord_q;
	logic              size_bad_q;
	logic [PG_W-1:0]   pg_q, tgt_q, clr_q;
	logic [LINK_W-1:0] hsave_q;
	logic [CNT_W-1:0]  off_q, rem_q, used_q, total_q, managed_q;
	logic              ready_q;

	logic [ORD_W:0]    want_w;
	logic [ORD_W-1:0]  cur;
	logic              found;
	logic [PG_W-1:0]   paddr, buddy, split_pg, push_pg;
	logic [CNT_W-1:0]  sat_pages, init_sz;
	logic [ORD_W-1:0]  pick;

	assign want_w    = want_of(request_bytes);
	assign paddr     = pair_addr(ord_q, pg_q);
	assign buddy     = pg_q ^ (PG_W'(1) << ord_q);
	assign split_pg  = pg_q + (PG_W'(1) << ord_q);
	assign push_pg   = (cmd.op == OP_PUSH_A_SPLIT) ? split_pg : pg_q;
	assign sat_pages = (managed_q > CNT_W'(MAX_PAGES)) ? CNT_W'(MAX_PAGES) : managed_q;
	assign pick      = init_pick(off_q, rem_q);
	assign init_sz   = CNT_W'(1) << ord_q;

	// lowest non-empty order at or above the wanted one
	always_comb begin
		found = 1'b0;
		cur = '0;
		for (int k = ORDER_COUNT - 1; k >= 0; k--) begin
			if (ORD_W'(k) >= want_q && !head_q[k][LINK_W-1]) begin
				found = 1'b1;
				cur = ORD_W'(k);
			end
		end
	end

	// status towards the sequencer
	always_comb begin
		sts.func        = func_q;
		sts.ready       = ready_q;
		sts.cfg_zero    = (managed_q == '0);
		sts.size_bad    = size_bad_q;
		sts.found       = found;
		sts.pg_ok       = ({1'b0, pg_q} < total_q);
		sts.ord_bad     = (order_rd_q >= ORD_W'(ORDER_COUNT));
		sts.ord_lt_max  = (ord_q < TOP_ORD);
		sts.ord_gt_want = (ord_q > want_q);
		sts.tog_new     = !pair_rd_q;
		sts.rem_zero    = (rem_q == '0);
		sts.clr_done    = (clr_q == '1);
	end

	// configuration register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			managed_q <= '0;
		else if (cfg_valid)
			managed_q <= cfg_data;
	end

	// control registers, heads and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q   <= '0;
			ready_q <= 1'b0;
			used_q  <= '0;
			total_q <= '0;
			rem_q   <= '0;
			off_q   <= '0;
			func_q  <= '0;
			ord_q   <= '0;
			pg_q    <= '0;
			want_q  <= '0;
			size_bad_q <= 1'b0;
			tgt_q   <= '0;
			hsave_q <= NIL_LINK;
			done    <= 1'b0;
			status  <= '0;
			granted_page <= '0;
			used_pages   <= '0;
			total_pages  <= '0;
			for (int k = 0; k < ORDER_COUNT; k++)
				head_q[k] <= NIL_LINK;
		end else begin
			done <= 1'b0;
			case (cmd.op)
				OP_CLR_STEP: clr_q <= clr_q + PG_W'(1);
				OP_LOAD: begin
					func_q <= func;
					pg_q <= page;
					want_q <= want_w[ORD_W-1:0];
					size_bad_q <= want_w[ORD_W];
				end
				OP_INIT_SETUP: begin
					for (int k = 0; k < ORDER_COUNT; k++)
						head_q[k] <= NIL_LINK;
					used_q <= '0;
					total_q <= sat_pages;
					rem_q <= sat_pages;
					off_q <= '0;
					ready_q <= 1'b1;
				end
				OP_INIT_PICK: begin
					ord_q <= pick;
					pg_q <= off_q[PG_W-1:0];
				end
				OP_INIT_ADV: begin
					off_q <= off_q + init_sz;
					rem_q <= rem_q - init_sz;
				end
				OP_PUSH_A_PG, OP_PUSH_A_SPLIT: begin
					tgt_q <= push_pg;
					hsave_q <= head_q[ord_q];
					head_q[ord_q] <= {1'b0, push_pg};
				end
				OP_UL_WR: begin
					if (prev_rd_q[LINK_W-1])
						head_q[ord_q] <= next_rd_q;
				end
				OP_ALLOC_FIND: begin
					ord_q <= cur;
					pg_q <= head_q[cur][PG_W-1:0];
				end
				OP_DEC_ORD: ord_q <= ord_q - ORD_W'(1);
				OP_ALLOC_DONE: used_q <= used_q + (CNT_W'(1) << want_q);
				OP_FREE_TAKE: begin
					ord_q <= order_rd_q;
					used_q <= used_q - (CNT_W'(1) << order_rd_q);
				end
				OP_MERGE: begin
					pg_q <= pg_q & ~(PG_W'(1) << ord_q);
					ord_q <= ord_q + ORD_W'(1);
				end
				OP_RESULT: begin
					done <= 1'b1;
					status <= cmd.code;
					granted_page <= cmd.grant ? pg_q : '0;
					used_pages <= ready_q ? used_q : '0;
					total_pages <= ready_q ? total_q : '0;
				end
				default: ;
			endcase
		end
	end

	// next link memory
	always_ff @(posedge clk) begin
		if (cmd.op == OP_PUSH_A_PG || cmd.op == OP_PUSH_A_SPLIT)
			next_mem[push_pg] <= head_q[ord_q];
		else if (cmd.op == OP_UL_WR && !prev_rd_q[LINK_W-1])
			next_mem[prev_rd_q[PG_W-1:0]] <= next_rd_q;
		if (cmd.op == OP_UL_RD_PG)
			next_rd_q <= next_mem[pg_q];
		else if (cmd.op == OP_UL_RD_BUDDY)
			next_rd_q <= next_mem[buddy];
	end

	// previous link memory
	always_ff @(posedge clk) begin
		if (cmd.op == OP_PUSH_A_PG || cmd.op == OP_PUSH_A_SPLIT)
			prev_mem[push_pg] <= NIL_LINK;
		else if (cmd.op == OP_PUSH_B && !hsave_q[LINK_W-1])
			prev_mem[hsave_q[PG_W-1:0]] <= {1'b0, tgt_q};
		else if (cmd.op == OP_UL_WR && !next_rd_q[LINK_W-1])
			prev_mem[next_rd_q[PG_W-1:0]] <= prev_rd_q;
		if (cmd.op == OP_UL_RD_PG)
			prev_rd_q <= prev_mem[pg_q];
		else if (cmd.op == OP_UL_RD_BUDDY)
			prev_rd_q <= prev_mem[buddy];
	end

	// stored order memory
	always_ff @(posedge clk) begin
		if (cmd.op == OP_CLR_STEP)
			order_mem[clr_q] <= FREE_MARK;
		else if (cmd.op == OP_FREE_TAKE)
			order_mem[pg_q] <= FREE_MARK;
		else if (cmd.op == OP_ALLOC_DONE)
			order_mem[pg_q] <= want_q;
		if (cmd.op == OP_ORD_RD)
			order_rd_q <= order_mem[pg_q];
	end

	// buddy pair toggle bits
	always_ff @(posedge clk) begin
		if (cmd.op == OP_CLR_STEP)
			pair_mem[clr_q] <= 1'b0;
		else if (cmd.op == OP_TOG_WR)
			pair_mem[paddr] <= !pair_rd_q;
		if (cmd.op == OP_TOG_RD)
			pair_rd_q <= pair_mem[paddr];
	end

endmodule

// ----- rtl/buddy_page_allocator_unit.sv -----
// Buddy page allocator over 4096 pages, eleven orders; one result word per command.
// The next word is accepted while done is high. One command at a time;
// the sequencer and single-port link memories set the pace. Reset clears
// control state, then a sweep over all 4096 entries clears stored orders
// and pair bits with busy high; init repeats that sweep. Results are
// strobed on done, never stalled.
module buddy_page_allocator_unit import bpa_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic [1:0]       func,
	input  logic [31:0]      request_bytes,
	input  logic [PG_W-1:0]  page,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CNT_W-1:0] cfg_data,
	output logic             done,
	output logic [2:0]       status,
	output logic [PG_W-1:0]  granted_page,
	output logic [CNT_W-1:0] used_pages,
	output logic [CNT_W-1:0] total_pages
);

	cmd_t cmd;
	sts_t sts;

	// sequencer
	bpa_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	// storage and arithmetic
	bpa_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.func          (func),
		.request_bytes (request_bytes),
		.page          (page),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.done          (done),
		.status        (status),
		.granted_page  (granted_page),
		.used_pages    (used_pages),
		.total_pages   (total_pages)
	);

endmodule

// ----- rtl/bpa_checker.sv -----
// bpa_props: port-level checks of buddy_page_allocator_unit, bound to the top level
// uses bpa_pkg
module bpa_props import bpa_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             start,
	input logic             busy,
	input logic             done,
	input logic [2:0]       status,
	input logic [PG_W-1:0]  granted_page,
	input logic [CNT_W-1:0] used_pages,
	input logic [CNT_W-1:0] total_pages
);

	// an accepted word keeps the unit busy in the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("accepted word did not raise busy");

	// a result only follows work in progress
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy)) else $error("result without work in progress");

	// granted page only on a successful allocate
	a_grant_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != ST_OK |-> granted_page == '0) else $error("stray granted page");

	// used pages never exceed the managed total
	a_used_le_total: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> used_pages <= total_pages) else $error("used above total");

endmodule

bind buddy_page_allocator_unit bpa_props u_bpa_props (.*);

// ----- sim/bpa_checker.sv -----
`timescale 1ns / 1ps
// bpa_checker: watches the command, config and result channels of the buddy page allocator,
// predicts every result word and compares it field by field; depends on bpa_pkg
module bpa_checker import bpa_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             busy,
	input  logic [1:0]       func,
	input  logic [31:0]      request_bytes,
	input  logic [PG_W-1:0]  page,
	input  logic             cfg_valid,
	input  logic             cfg_ready,
	input  logic [CNT_W-1:0] cfg_data,
	input  logic             done,
	input  logic [2:0]       status,
	input  logic [PG_W-1:0]  granted_page,
	input  logic [CNT_W-1:0] used_pages,
	input  logic [CNT_W-1:0] total_pages,
	output int               errors,
	output int               pending
);

	typedef struct {
		st_code_t         st;
		logic [PG_W-1:0]  gp;
		logic [CNT_W-1:0] used;
		logic [CNT_W-1:0] total;
	} alloc_word_t;

	alloc_word_t expected_words[$];

	// shadow allocator state
	int   pages_cfg;
	bit   is_ready;
	int   head[ORDER_COUNT];
	int   nxt[MAX_PAGES];
	int   prv[MAX_PAGES];
	int   blk_ord[MAX_PAGES];
	bit   pair[ORDER_COUNT][MAX_PAGES/2];
	int   used_cnt;
	int   total_cnt;

	function automatic bit flip_pair(int o, int pg);
		int idx;
		idx = pg >> (o + 1);
		pair[o][idx] = !pair[o][idx];
		return pair[o][idx];
	endfunction

	function automatic void list_push(int o, int pg);
		int h;
		h = head[o];
		prv[pg] = MAX_PAGES;
		nxt[pg] = h;
		if (h < MAX_PAGES)
			prv[h] = pg;
		head[o] = pg;
	endfunction

	function automatic void list_unlink(int o, int pg);
		int pr;
		int nx;
		pr = prv[pg];
		nx = nxt[pg];
		if (pr < MAX_PAGES)
			nxt[pr] = nx;
		else
			head[o] = nx;
		if (nx < MAX_PAGES)
			prv[nx] = pr;
	endfunction

	function automatic void wipe_lists();
		for (int k = 0; k < ORDER_COUNT; k++)
			head[k] = MAX_PAGES;
		for (int k = 0; k < ORDER_COUNT; k++)
			for (int i = 0; i < MAX_PAGES/2; i++)
				pair[k][i] = 0;
		for (int i = 0; i < MAX_PAGES; i++)
			blk_ord[i] = 255;
		used_cnt = 0;
	endfunction

	// work out the result word of one accepted command
	function automatic void predict_word(logic [1:0] f, logic [31:0] bytes, logic [PG_W-1:0] p);
		alloc_word_t w;
		int rem;
		int off;
		int want;
		int cur;
		int blk;
		int o;
		int pg;
		bit placed;
		w.st = ST_OK;
		w.gp = '0;
		if (f == FN_INIT) begin
			rem = pages_cfg;
			off = 0;
			if (rem == 0) begin
				w.st = ST_BADSIZE;
			end else begin
				if (rem > MAX_PAGES)
					rem = MAX_PAGES;
				wipe_lists();
				total_cnt = rem;
				while (rem > 0) begin
					placed = 0;
					for (int k = ORDER_COUNT - 1; k >= 0 && !placed; k--) begin
						if ((1 << k) <= rem && (off & ((1 << k) - 1)) == 0) begin
							void'(flip_pair(k, off));
							list_push(k, off);
							off += 1 << k;
							rem -= 1 << k;
							placed = 1;
						end
					end
				end
				is_ready = 1;
			end
		end else if (f == FN_ALLOC) begin
			if (!is_ready) begin
				w.st = ST_NOINIT;
			end else if (bytes == 0) begin
				w.st = ST_BADSIZE;
			end else begin
				want = 0;
				while (want < ORDER_COUNT && (64'd1 << (PAGE_SHIFT + want)) < 64'(bytes))
					want++;
				if (want >= ORDER_COUNT) begin
					w.st = ST_BADSIZE;
				end else begin
					cur = want;
					while (cur < ORDER_COUNT && head[cur] >= MAX_PAGES)
						cur++;
					if (cur >= ORDER_COUNT) begin
						w.st = ST_OOM;
					end else begin
						blk = head[cur];
						list_unlink(cur, blk);
						void'(flip_pair(cur, blk));
						while (cur > want) begin
							cur--;
							list_push(cur, blk + (1 << cur));
							void'(flip_pair(cur, blk));
						end
						blk_ord[blk] = want;
						used_cnt += 1 << want;
						w.gp = PG_W'(blk);
					end
				end
			end
		end else if (f == FN_FREE) begin
			pg = int'(p);
			if (!is_ready) begin
				w.st = ST_NOINIT;
			end else if (pg >= total_cnt || blk_ord[pg] >= ORDER_COUNT) begin
				w.st = ST_IGNORED;
			end else begin
				o = blk_ord[pg];
				blk_ord[pg] = 255;
				used_cnt -= 1 << o;
				// merge upward while the buddy is free
				while (o + 1 < ORDER_COUNT) begin
					if (flip_pair(o, pg))
						break;
					list_unlink(o, pg ^ (1 << o));
					pg &= ~(1 << o);
					o++;
				end
				list_push(o, pg);
			end
		end else begin
			w.st = ST_IGNORED;
		end
		w.used  = is_ready ? CNT_W'(used_cnt) : '0;
		w.total = is_ready ? CNT_W'(total_cnt) : '0;
		expected_words.push_back(w);
	endfunction

	assign pending = expected_words.size();

	always @(posedge clk or negedge arst_n) begin
		alloc_word_t e;
		if (!arst_n) begin
			pages_cfg = 0;
			is_ready = 0;
			total_cnt = 0;
			errors = 0;
			wipe_lists();
			expected_words.delete();
		end else begin
			if (cfg_valid && cfg_ready)
				pages_cfg = int'(cfg_data);
			// result word
			if (done) begin
				if (expected_words.size() == 0) begin
					errors++;
					$display("%t: result word with none expected, status %0d", $time, status);
				end else begin
					e = expected_words.pop_front();
					if (status !== e.st) begin
						errors++;
						$display("%t: status exp %0d got %0d", $time, e.st, status);
					end
					if (granted_page !== e.gp) begin
						errors++;
						$display("%t: granted_page exp %0d got %0d", $time, e.gp, granted_page);
					end
					if (used_pages !== e.used) begin
						errors++;
						$display("%t: used_pages exp %0d got %0d", $time, e.used, used_pages);
					end
					if (total_pages !== e.total) begin
						errors++;
						$display("%t: total_pages exp %0d got %0d", $time, e.total, total_pages);
					end
				end
			end
			// command word
			if (start && !busy)
				predict_word(func, request_bytes, page);
		end
	end

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// tb_top: stimulus and verdict for buddy_page_allocator_unit, directed then random phases
// depends on bpa_pkg, buddy_page_allocator_unit and bpa_checker
module tb_top;
	import bpa_pkg::*;

	localparam logic [1:0] FN_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 2000000;
	localparam int PHASE_ITEMS = 175;

	logic             clk = 0;
	logic             arst_n = 0;
	logic             start = 0;
	logic             busy;
	logic [1:0]       func = FN_INIT;
	logic [31:0]      request_bytes = '0;
	logic [PG_W-1:0]  page = '0;
	logic             cfg_valid = 0;
	logic             cfg_ready;
	logic [CNT_W-1:0] cfg_data = '0;
	logic             done;
	logic [2:0]       status;
	logic [PG_W-1:0]  granted_page;
	logic [CNT_W-1:0] used_pages;
	logic [CNT_W-1:0] total_pages;
	int               errors;
	int               pending;
	int               cycles = 0;
	int               gap_pct = 0;

	logic [1:0]       issued_funcs[$];
	logic [PG_W-1:0]  live_blocks[$];

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	buddy_page_allocator_unit i_dut (.*);

	bpa_checker i_checker (.*);

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_top: done, errors");
			$finish;
		end
	end

	// track granted blocks so that frees can target them
	always @(posedge clk) begin
		logic [1:0] f;
		if (done && issued_funcs.size() > 0) begin
			f = issued_funcs.pop_front();
			if (f == FN_INIT && status == ST_OK)
				live_blocks.delete();
			if (f == FN_ALLOC && status == ST_OK)
				live_blocks.push_back(granted_page);
		end
	end

	// one command word, with random idle cycles ahead of it
	task automatic send(logic [1:0] f, logic [31:0] b, logic [PG_W-1:0] p);
		while ($urandom_range(99) < gap_pct) begin
			start <= 0;
			@(posedge clk);
		end
		start <= 1;
		func <= f;
		request_bytes <= b;
		page <= p;
		forever begin
			@(negedge clk);
			if (!busy) begin
				@(posedge clk);
				break;
			end
			@(posedge clk);
		end
		issued_funcs.push_back(f);
	endtask

	task automatic drain();
		start <= 0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	task automatic write_pages(logic [CNT_W-1:0] v);
		cfg_valid <= 1;
		cfg_data <= v;
		forever begin
			@(negedge clk);
			if (cfg_ready) begin
				@(posedge clk);
				break;
			end
			@(posedge clk);
		end
		cfg_valid <= 0;
	endtask

	task automatic random_alloc();
		int o;
		o = ($urandom_range(9) == 0) ? $urandom_range(10) : $urandom_range(3);
		send(FN_ALLOC, $urandom_range(1 << (PAGE_SHIFT + o), 1), PG_W'($urandom));
	endtask

	initial begin
		logic [PG_W-1:0] p;
		int r;
		int idx;
		logic [CNT_W-1:0] sizes[8];
		sizes = '{4096, 1, 8191, 37, 0, 4095, 0, 2};
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// before init, zero-page init, saturated init, size edges
		send(FN_ALLOC, 1, 0);
		send(FN_FREE, 0, 0);
		send(FN_UNUSED, '1, '1);
		drain();
		write_pages(0);
		send(FN_INIT, 0, 0);
		drain();
		write_pages(8191);
		send(FN_INIT, 0, 0);
		send(FN_ALLOC, 0, 0);
		send(FN_ALLOC, 1, 0);
		send(FN_ALLOC, 4097, 0);
		send(FN_ALLOC, 32'd4194304, 0);
		send(FN_ALLOC, 32'd4194305, 0);
		send(FN_ALLOC, 32'hFFFF_FFFF, 0);
		send(FN_ALLOC, 8192, 0);
		drain();
		// free inside a block, then a double free and an unallocated page
		p = live_blocks[$];
		send(FN_FREE, 0, p + PG_W'(1));
		send(FN_FREE, 0, p);
		send(FN_FREE, 0, p);
		send(FN_FREE, 0, 4095);
		send(FN_UNUSED, 0, 0);
		drain();
		// tiny pool: out of memory and a page beyond the range
		write_pages(3);
		send(FN_INIT, 0, 0);
		repeat (4)
			send(FN_ALLOC, 4096, 0);
		send(FN_FREE, 0, 4000);
		drain();

		// random phases, each setting a pool size and an idle pattern
		for (int ph = 0; ph < 8; ph++) begin
			gap_pct = (ph % 3 == 0) ? 0 : (ph % 3 == 1) ? 66 : 14;
			if (sizes[ph] == 0)
				sizes[ph] = CNT_W'($urandom_range(4096, 1));
			drain();
			write_pages(sizes[ph]);
			send(FN_INIT, 0, 0);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				r = $urandom_range(99);
				if (r < 45) begin
					random_alloc();
				end else if (r < 85 && live_blocks.size() > 0) begin
					idx = $urandom_range(live_blocks.size() - 1);
					p = live_blocks[idx];
					live_blocks.delete(idx);
					send(FN_FREE, $urandom, p);
				end else if (r < 91) begin
					send(FN_FREE, $urandom, PG_W'($urandom));
				end else if (r < 96) begin
					send(FN_ALLOC, $urandom, PG_W'($urandom));
				end else if (r < 98) begin
					send(FN_UNUSED, $urandom, PG_W'($urandom));
				end else begin
					send(FN_INIT, $urandom, PG_W'($urandom));
				end
			end
		end

		drain();
		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/bpa_pkg.sv
rtl/bpa_ctrl.sv
rtl/bpa_datapath.sv
rtl/buddy_page_allocator_unit.sv
rtl/bpa_checker.sv
sim/bpa_checker.sv
sim/tb_top.sv
